// ===== sv/gauge_level_smoother_with_interlock_defines.svh =====
// Assertion macros shared by the gauge level smoother RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GAUGE_LEVEL_SMOOTHER_WITH_INTERLOCK_DEFINES_SVH
`define GAUGE_LEVEL_SMOOTHER_WITH_INTERLOCK_DEFINES_SVH
`ifndef SYNTHESIS
`define GLS_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define GLS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define GLS_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define GLS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== sv/gls_pkg.sv =====
// Package for the gauge level smoother: beat types, register indexes,
// reset values and datapath widths. No dependencies.
package gls_pkg;

  localparam int SAMPLES_PER_UPDATE_DEF = 10;
  localparam int ADC_FULL_SCALE_DEF     = 4095;

  localparam int SUM_W  = 16;   // running sums
  localparam int MAG_W  = 24;   // |avg * (max - min)|
  localparam int SD_W   = 24;   // smoothed duty, Q8.16
  localparam int WGT_W  = 17;   // filter weight, Q1.16 up to 1.0
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;

  localparam logic [CFG_IW-1:0] REG_DUTY_MIN     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DUTY_MAX     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BLINK_BELOW  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KILL_BELOW   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BLINK_PERIOD = 3'd4;
  localparam logic [CFG_IW-1:0] REG_HOT_ADC_MAX  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_FAULT_FLOOR  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SMOOTH_WGT   = 3'd7;

  localparam logic [7:0]       RST_DUTY_MIN     = 8'd140;
  localparam logic [7:0]       RST_DUTY_MAX     = 8'd225;
  localparam logic [7:0]       RST_BLINK_BELOW  = 8'd150;
  localparam logic [7:0]       RST_KILL_BELOW   = 8'd145;
  localparam logic [15:0]      RST_BLINK_PERIOD = 16'd250;
  localparam logic [11:0]      RST_HOT_ADC_MAX  = 12'd815;
  localparam logic [11:0]      RST_FAULT_FLOOR  = 12'd124;
  localparam logic [WGT_W-1:0] RST_SMOOTH_WGT   = 17'd3277;
  localparam logic [WGT_W-1:0] ONE_Q16          = 17'h10000;
  localparam logic [SD_W-1:0]  RST_SMOOTHED     = 24'h8C0000;  // 140.0

  typedef struct packed {
    logic [11:0] level_sample;
    logic [11:0] therm_sample;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  gauge_duty;
    logic        backlight_on;
    logic        power_enable;
    logic        over_temp;
    logic        sensor_fault;
    logic [11:0] level_average;
  } out_item_t;

endpackage

// ===== sv/gls_stream_if.sv =====
// Valid/ready stream channel carrying one beat of type T.
// Generic; the payload type comes from gls_pkg at the point of use.
interface gls_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gls_sdiv.sv =====
// Bit-serial restoring divider by a constant: one quotient bit per cycle.
// Standalone; used for the group averages and the duty mapping.
module gls_sdiv #(
  parameter int NW      = 16,
  parameter int DIVISOR = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int DW = $clog2(DIVISOR + 1);
  localparam int CW = $clog2(NW + 1);
  localparam logic [DW:0] DIV_V = (DW + 1)'(DIVISOR);
  localparam logic [CW-1:0] STEPS = CW'(NW);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // shift the next dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    trial   = {rem_r, q_r[NW-1]};
    diff    = trial - DIV_V;
    ge      = (trial >= DIV_V);
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    q_nxt   = {q_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ONE_C;
        if (cnt_r == ONE_C) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

// ===== sv/gls_smul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Standalone; used for the decay term of the duty filter.
module gls_smul #(
  parameter int AW = 24,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] product,
  output logic             done
);

  localparam int CW = $clog2(BW + 1);
  localparam logic [CW-1:0] STEPS = CW'(BW);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [AW-1:0] a_r;
  logic [AW-1:0] hi_r;
  logic [BW-1:0] lo_r;
  logic [AW:0]   sum;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  // add the multiplicand under the current bit, then shift the pair right
  always_comb begin
    sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ONE_C;
        if (cnt_r == ONE_C) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[AW:1];
      lo_r <= {sum[0], lo_r[BW-1:1]};
    end
  end

  assign product = {hi_r, lo_r};
  assign done    = done_r;

endmodule

// ===== sv/gauge_level_smoother_with_interlock.sv =====
// Gauge level smoother with low-level and over-temperature interlock.
// A beat that does not close a group goes straight into the running sums. The beat
// that closes a group runs the serial averages, then the serial duty mapping
// divide, then the serial filter multiply, with control steps between them; one
// item at a time through these serial units.
// Synchronous active-low reset restores registers, sums and filter state.
`include "gauge_level_smoother_with_interlock_defines.svh"
module gauge_level_smoother_with_interlock #(
  parameter int SAMPLES_PER_UPDATE = gls_pkg::SAMPLES_PER_UPDATE_DEF,
  parameter int ADC_FULL_SCALE     = gls_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gls_stream_if.sink                in_if,
  gls_stream_if.source              out_if,
  input  logic                      cfg_we,
  input  logic [gls_pkg::CFG_IW-1:0] cfg_index,
  input  logic [gls_pkg::CFG_DW-1:0] cfg_wdata
);
  import gls_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_UPDATE + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_UPDATE - 1);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AVG   = 3'd1;
  localparam logic [2:0] ST_MAPST = 3'd2;
  localparam logic [2:0] ST_MAP   = 3'd3;
  localparam logic [2:0] ST_FILT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // configuration registers
  logic [7:0]       duty_min_r, duty_max_r, blink_below_r, kill_below_r;
  logic [15:0]      blink_period_r;
  logic [11:0]      hot_max_r, fault_floor_r;
  logic [WGT_W-1:0] weight_r;

  // control and state
  logic [2:0]       st_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] lsum_r, tsum_r, lsum_nxt, tsum_nxt;
  logic [SD_W-1:0]  sd_r, sd_nxt;
  logic             phase_r, phase_nxt;
  logic             bl_r, bl_nxt;
  logic [31:0]      last_r, last_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // datapath registers
  logic [31:0]      now_r;
  logic [SUM_W-1:0] lavg_r, tavg_r;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;
  logic [7:0]       target_r;
  logic [24:0]      wt_r;

  logic             in_fire, last_grp;
  logic [SUM_W-1:0] ldiv_q, tdiv_q;
  logic             ldiv_done, tdiv_done;
  logic [MAG_W-1:0] mdiv_q;
  logic             mdiv_done;
  logic [SD_W+WGT_W-1:0] mul_p;
  logic             mul_done;
  logic [7:0]       absdiff;
  logic signed [25:0] tsum;
  logic [7:0]       target_sat;
  logic [WGT_W-1:0] w_sat, w_rest;
  logic [7:0]       duty;
  logic [31:0]      elapsed;
  logic             fault, hot, kill;
  logic [25:0]      filt_sum;

  assign last_grp = (cnt_r == LAST_CNT);
  // a group-closing beat needs the result register free
  assign in_if.ready = (st_r == ST_IDLE) && (!last_grp || !out_valid_r);
  assign in_fire     = in_if.valid && in_if.ready;

  assign lsum_nxt = lsum_r + SUM_W'(in_if.data.level_sample);
  assign tsum_nxt = tsum_r + SUM_W'(in_if.data.therm_sample);

  gls_sdiv #(.NW(SUM_W), .DIVISOR(SAMPLES_PER_UPDATE)) u_ldiv (
    .clk(clk), .rst_n(rst_n), .start(in_fire && last_grp),
    .dividend(lsum_nxt), .quotient(ldiv_q), .done(ldiv_done)
  );

  gls_sdiv #(.NW(SUM_W), .DIVISOR(SAMPLES_PER_UPDATE)) u_tdiv (
    .clk(clk), .rst_n(rst_n), .start(in_fire && last_grp),
    .dividend(tsum_nxt), .quotient(tdiv_q), .done(tdiv_done)
  );

  gls_sdiv #(.NW(MAG_W), .DIVISOR(ADC_FULL_SCALE)) u_mdiv (
    .clk(clk), .rst_n(rst_n), .start(st_r == ST_MAPST),
    .dividend(mag_r), .quotient(mdiv_q), .done(mdiv_done)
  );

  assign w_sat  = (weight_r > ONE_Q16) ? ONE_Q16 : weight_r;
  assign w_rest = ONE_Q16 - w_sat;

  gls_smul #(.AW(SD_W), .BW(WGT_W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start((st_r == ST_MAP) && mdiv_done),
    .a(sd_r), .b(w_rest), .product(mul_p), .done(mul_done)
  );

  // duty mapping: truncate toward zero, then clamp to 0..255
  always_comb begin
    absdiff = (duty_max_r < duty_min_r) ? (duty_min_r - duty_max_r)
                                        : (duty_max_r - duty_min_r);
    if (neg_r) begin
      tsum = $signed({18'd0, duty_min_r}) - $signed({2'b00, mdiv_q});
    end else begin
      tsum = $signed({18'd0, duty_min_r}) + $signed({2'b00, mdiv_q});
    end
    if (tsum[25]) begin
      target_sat = 8'd0;
    end else if (tsum > 26'sd255) begin
      target_sat = 8'd255;
    end else begin
      target_sat = tsum[7:0];
    end
  end

  // filter: w*target + floor((1-w)*s), kept to 24 bits
  assign filt_sum = {1'b0, wt_r} + {1'b0, mul_p[SD_W+WGT_W-1:16]};
  assign sd_nxt   = filt_sum[SD_W-1:0];

  // blink, temperature window and kill on the finished duty
  always_comb begin
    duty      = sd_r[SD_W-1:16];
    elapsed   = now_r - last_r;
    phase_nxt = phase_r;
    bl_nxt    = bl_r;
    last_nxt  = last_r;
    if (duty < blink_below_r) begin
      if (elapsed >= {16'd0, blink_period_r}) begin
        last_nxt  = now_r;
        phase_nxt = ~phase_r;
        bl_nxt    = ~phase_r;
      end
    end else begin
      bl_nxt = 1'b0;
    end
    fault = (tavg_r <= {4'd0, fault_floor_r});
    hot   = !fault && (tavg_r <= {4'd0, hot_max_r});
    kill  = (duty < kill_below_r) || hot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_min_r     <= RST_DUTY_MIN;
      duty_max_r     <= RST_DUTY_MAX;
      blink_below_r  <= RST_BLINK_BELOW;
      kill_below_r   <= RST_KILL_BELOW;
      blink_period_r <= RST_BLINK_PERIOD;
      hot_max_r      <= RST_HOT_ADC_MAX;
      fault_floor_r  <= RST_FAULT_FLOOR;
      weight_r       <= RST_SMOOTH_WGT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUTY_MIN:     duty_min_r     <= cfg_wdata[7:0];
        REG_DUTY_MAX:     duty_max_r     <= cfg_wdata[7:0];
        REG_BLINK_BELOW:  blink_below_r  <= cfg_wdata[7:0];
        REG_KILL_BELOW:   kill_below_r   <= cfg_wdata[7:0];
        REG_BLINK_PERIOD: blink_period_r <= cfg_wdata[15:0];
        REG_HOT_ADC_MAX:  hot_max_r      <= cfg_wdata[11:0];
        REG_FAULT_FLOOR:  fault_floor_r  <= cfg_wdata[11:0];
        REG_SMOOTH_WGT:   weight_r       <= cfg_wdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      lsum_r      <= '0;
      tsum_r      <= '0;
      sd_r        <= RST_SMOOTHED;
      phase_r     <= 1'b0;
      bl_r        <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (last_grp) begin
              cnt_r  <= '0;
              lsum_r <= '0;
              tsum_r <= '0;
              st_r   <= ST_AVG;
            end else begin
              cnt_r  <= cnt_r + ONE_CNT;
              lsum_r <= lsum_nxt;
              tsum_r <= tsum_nxt;
            end
          end
        end
        ST_AVG: begin
          if (ldiv_done && tdiv_done) begin
            st_r <= ST_MAPST;
          end
        end
        ST_MAPST: begin
          st_r <= ST_MAP;
        end
        ST_MAP: begin
          if (mdiv_done) begin
            st_r <= ST_FILT;
          end
        end
        ST_FILT: begin
          if (mul_done) begin
            sd_r <= sd_nxt;
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          phase_r     <= phase_nxt;
          bl_r        <= bl_nxt;
          last_r      <= last_nxt;
          out_valid_r <= 1'b1;
          st_r        <= ST_IDLE;
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_grp) begin
      now_r <= in_if.data.now_ms;
    end
    if ((st_r == ST_AVG) && ldiv_done) begin
      lavg_r <= ldiv_q;
      tavg_r <= tdiv_q;
      mag_r  <= MAG_W'(ldiv_q) * MAG_W'(absdiff);
      neg_r  <= (duty_max_r < duty_min_r);
    end
    if ((st_r == ST_MAP) && mdiv_done) begin
      target_r <= target_sat;
    end
    wt_r <= 25'(w_sat) * 25'(target_r);
    if (st_r == ST_OUT) begin
      out_data_r.gauge_duty    <= duty;
      out_data_r.backlight_on  <= bl_nxt;
      out_data_r.power_enable  <= !kill;
      out_data_r.over_temp     <= hot;
      out_data_r.sensor_fault  <= fault;
      out_data_r.level_average <= lavg_r[11:0];
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  `GLS_ASSERT_SAME(a_no_overwrite, clk, rst_n, st_r == ST_OUT, !out_valid_r, "result register overwritten")
  `GLS_ASSERT_NEXT(a_group_clear, clk, rst_n, in_fire && last_grp, (cnt_r == '0) && (lsum_r == '0) && (st_r == ST_AVG), "group not cleared on closing beat")
  `GLS_ASSERT_SAME(a_div_lockstep, clk, rst_n, ldiv_done || tdiv_done, ldiv_done && tdiv_done && (st_r == ST_AVG), "average dividers out of step")

endmodule
